>>> sv/wpwr_pkg.sv
// shared types, constants and codes for the weighted pick block
package wpwr_pkg;

   // fixed field widths
   localparam int IDX_BITS    = 3;
   localparam int SLOTS       = 8;
   localparam int FRAC_BITS   = 17;
   localparam int FRAC_SHIFT  = 16;
   localparam int COUNT_BITS  = 4;
   localparam int CFG_BITS    = 16;
   localparam int APB_DATA    = 32;
   localparam int APB_ADDR    = 5;

   localparam logic [FRAC_BITS-1:0] FRAC_ONE = FRAC_BITS'(65536);

   // defaults for the top level parameters
   localparam int DEFAULT_ENTRIES     = 8;
   localparam int DEFAULT_WEIGHT_BITS = 16;

   // action codes
   localparam logic ACT_START = 1'b0;
   localparam logic ACT_DRAW  = 1'b1;

   // status codes
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_SPENT = 1'b1;

   // stored weight width: register width masked to the weight parameter
   function automatic int weight_width(input int bits);
      int w;
      w = (bits < CFG_BITS) ? bits : CFG_BITS;
      return w;
   endfunction

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_COUNT,
      ST_MUL,
      ST_WALK,
      ST_SWAP,
      ST_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic load_init;
      logic load_step;
      logic count;
      logic set_spent;
      logic mul;
      logic walk_step;
      logic swap;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_start;
      logic spent;
      logic load_done;
      logic walk_hit;
      logic out_free;
   } stat_type;

endpackage

>>> sv/weighted_pick_without_replacement_top.sv
// top level of the weighted pick without replacement block
//
// usage: write weight_0..weight_7 over the apb-style port (byte address 4*i)
// while the block is idle. a word on the req channel with action start
// loads every entry of nonzero weight, sums the weights and plans the pick
// count; its rsp word carries pick_count. each draw word returns one entry
// in picked_entry, removes it, and flags last_pick on the final planned
// pick. a draw with no picks left answers status spent.
// a start runs the load sweep over the weight registers, then plans the
// pick count. a draw walks the entries through the entry ram read port
// until the target interval is hit, after the total-times-fraction
// multiply and before the swap write. one word is in work at a time; the
// next word is accepted the cycle after the result goes to the output
// register, even while rsp is stalled.
// reset (synchronous) clears the weights, the pick count and the totals; the
// entry ram needs no clearing. while rsp_stall is high the result word holds
// and a finished second result waits in the block with req_stall high.
module weighted_pick_without_replacement_top #(
   parameter int ENTRIES     = wpwr_pkg::DEFAULT_ENTRIES,
   parameter int WEIGHT_BITS = wpwr_pkg::DEFAULT_WEIGHT_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_action,
   input  logic [wpwr_pkg::FRAC_BITS-1:0]       req_random_fraction,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [wpwr_pkg::IDX_BITS-1:0]        rsp_picked_entry,
   output logic [wpwr_pkg::COUNT_BITS-1:0]      rsp_pick_count,
   output logic                                 rsp_last_pick,
   output logic                                 rsp_status,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [wpwr_pkg::APB_ADDR-1:0]        paddr,
   input  logic [wpwr_pkg::APB_DATA-1:0]        pwdata,
   output logic [wpwr_pkg::APB_DATA-1:0]        prdata,
   output logic                                 pready
);
   import wpwr_pkg::*;

   localparam int W = weight_width(WEIGHT_BITS);

   cmd_type                 cmd;
   stat_type                stat;
   logic [SLOTS-1:0][W-1:0] weights;

   // configuration registers
   wpwr_csr #(
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .weights (weights)
   );

   // sequencing
   wpwr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // storage and arithmetic
   wpwr_datapath #(
      .ENTRIES     (ENTRIES),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .weights             (weights),
      .req_action          (req_action),
      .req_random_fraction (req_random_fraction),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_picked_entry    (rsp_picked_entry),
      .rsp_pick_count      (rsp_pick_count),
      .rsp_last_pick       (rsp_last_pick),
      .rsp_status          (rsp_status)
   );

endmodule

>>> sv/wpwr_ram.sv
// generic single write port ram with registered read
module wpwr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/wpwr_csr.sv
// weight register file behind the apb-style configuration port
module wpwr_csr #(
   parameter int WEIGHT_BITS = wpwr_pkg::DEFAULT_WEIGHT_BITS,
   localparam int W = wpwr_pkg::weight_width(WEIGHT_BITS)
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     psel,
   input  logic                                     penable,
   input  logic                                     pwrite,
   input  logic [wpwr_pkg::APB_ADDR-1:0]            paddr,
   input  logic [wpwr_pkg::APB_DATA-1:0]            pwdata,
   output logic [wpwr_pkg::APB_DATA-1:0]            prdata,
   output logic                                     pready,
   output logic [wpwr_pkg::SLOTS-1:0][W-1:0]        weights
);
   import wpwr_pkg::*;

   logic [SLOTS-1:0][W-1:0] weight_ff;
   logic [IDX_BITS-1:0]     reg_idx;
   logic                    wr_fire;

   assign reg_idx = paddr[IDX_BITS+1:2];
   assign wr_fire = psel && penable && pwrite;

   // register writes, masked to the stored width
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= '0;
      end else if (wr_fire) begin
         weight_ff[reg_idx] <= pwdata[W-1:0];
      end
   end

   assign prdata  = APB_DATA'(weight_ff[reg_idx]);
   assign pready  = 1'b1;
   assign weights = weight_ff;

endmodule

>>> sv/wpwr_datapath.sv
// datapath: entry store, running totals, walk compare and result register
module wpwr_datapath #(
   parameter int ENTRIES     = wpwr_pkg::DEFAULT_ENTRIES,
   parameter int WEIGHT_BITS = wpwr_pkg::DEFAULT_WEIGHT_BITS,
   localparam int W = wpwr_pkg::weight_width(WEIGHT_BITS)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  wpwr_pkg::cmd_type                    cmd,
   output wpwr_pkg::stat_type                   stat,
   input  logic [wpwr_pkg::SLOTS-1:0][W-1:0]    weights,
   input  logic                                 req_action,
   input  logic [wpwr_pkg::FRAC_BITS-1:0]       req_random_fraction,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [wpwr_pkg::IDX_BITS-1:0]        rsp_picked_entry,
   output logic [wpwr_pkg::COUNT_BITS-1:0]      rsp_pick_count,
   output logic                                 rsp_last_pick,
   output logic                                 rsp_status
);
   import wpwr_pkg::*;

   localparam int TW = W + IDX_BITS;
   localparam int PW = TW + FRAC_BITS;
   localparam int RA = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RW = IDX_BITS + W;
   localparam int NW = COUNT_BITS + FRAC_BITS;
   localparam logic [IDX_BITS-1:0] LAST_LOAD = IDX_BITS'(ENTRIES - 1);

   // round state
   logic [COUNT_BITS-1:0]       size_ff, size_in;
   logic [COUNT_BITS-1:0]       picks_ff, picks_in;
   logic [TW-1:0]               total_ff, total_in;
   // per item work registers
   logic [FRAC_BITS-1:0]        frac_ff;
   logic [ENTRIES-1:0][W-1:0]   load_ff, load_in;
   logic [IDX_BITS-1:0]         load_idx_ff, load_idx_in;
   logic [PW-1:0]               target_ff;
   logic [TW-1:0]               cum_ff, cum_in;
   logic [IDX_BITS-1:0]         walk_idx_ff, walk_idx_in;
   logic [IDX_BITS-1:0]         pick_idx_ff;
   logic [IDX_BITS-1:0]         pick_entry_ff;
   logic [W-1:0]                pick_w_ff;
   // pending result word
   logic [IDX_BITS-1:0]         res_entry_ff;
   logic [COUNT_BITS-1:0]       res_count_ff;
   logic                        res_last_ff;
   logic                        res_status_ff;
   // output register
   logic                        rsp_valid_ff;
   logic [IDX_BITS-1:0]         rsp_entry_ff;
   logic [COUNT_BITS-1:0]       rsp_count_ff;
   logic                        rsp_last_ff;
   logic                        rsp_status_ff;

   // ram ports
   logic                        ram_wr_en;
   logic [RA-1:0]               ram_wr_addr;
   logic [RW-1:0]               ram_wr_data;
   logic                        ram_rd_en;
   logic [RA-1:0]               ram_rd_addr;
   logic [RW-1:0]               ram_rd_data;
   logic [IDX_BITS-1:0]         rd_entry;
   logic [W-1:0]                rd_weight;

   // combinational helpers
   logic [FRAC_BITS-1:0]        frac_sat;
   logic [IDX_BITS-1:0]         last_idx;
   logic [COUNT_BITS-1:0]       size_dec;
   logic [TW-1:0]               cum_next;
   logic [PW-1:0]               cum_scaled;
   logic                        walk_hit;
   logic [NW-1:0]               n_times_r;
   logic [COUNT_BITS:0]         count_plus;
   logic [COUNT_BITS-1:0]       count_val;

   assign frac_sat   = (req_random_fraction > FRAC_ONE) ? FRAC_ONE : req_random_fraction;
   assign size_dec   = size_ff - COUNT_BITS'(1);
   assign last_idx   = size_dec[IDX_BITS-1:0];
   assign rd_entry   = ram_rd_data[RW-1:W];
   assign rd_weight  = ram_rd_data[W-1:0];

   // running sum and interval test for the entry now read
   assign cum_next   = cum_ff + TW'(rd_weight);
   assign cum_scaled = PW'({cum_next, {FRAC_SHIFT{1'b0}}});
   assign walk_hit   = (target_ff <= cum_scaled) || (walk_idx_ff == last_idx);

   // planned pick count from entry count and fraction
   assign n_times_r  = NW'(size_ff) * NW'(frac_ff);
   assign count_plus = n_times_r[NW-1:FRAC_SHIFT] + (COUNT_BITS+1)'(1);
   always_comb begin
      if (frac_ff >= FRAC_ONE) begin
         count_val = size_ff;
      end else if (count_plus > {1'b0, size_ff}) begin
         count_val = size_ff;
      end else begin
         count_val = count_plus[COUNT_BITS-1:0];
      end
   end

   // ram address and data selection
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = size_ff[RA-1:0];
      ram_wr_data = {load_idx_ff, load_ff[0]};
      ram_rd_en   = cmd.mul || cmd.walk_step;
      ram_rd_addr = '0;
      if (cmd.load_step && (load_ff[0] != '0)) begin
         ram_wr_en = 1'b1;
      end
      if (cmd.swap) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = pick_idx_ff[RA-1:0];
         ram_wr_data = ram_rd_data;
      end
      if (cmd.walk_step) begin
         if (walk_hit) begin
            ram_rd_addr = last_idx[RA-1:0];
         end else begin
            ram_rd_addr = RA'(walk_idx_ff + IDX_BITS'(1));
         end
      end
   end

   wpwr_ram #(
      .WIDTH (RW),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // next values of the round state and the load shift line
   always_comb begin
      size_in     = size_ff;
      picks_in    = picks_ff;
      total_in    = total_ff;
      load_in     = load_ff;
      load_idx_in = load_idx_ff;
      cum_in      = cum_ff;
      walk_idx_in = walk_idx_ff;
      if (cmd.load_init) begin
         size_in     = '0;
         total_in    = '0;
         load_idx_in = '0;
         for (int j = 0; j < ENTRIES; j++) begin
            load_in[j] = weights[j];
         end
      end
      if (cmd.load_step) begin
         if (load_ff[0] != '0) begin
            size_in  = size_ff + COUNT_BITS'(1);
            total_in = total_ff + TW'(load_ff[0]);
         end
         load_idx_in = load_idx_ff + IDX_BITS'(1);
         // shift toward slot zero, top slot empties
         load_in = load_ff >> W;
      end
      if (cmd.count) begin
         picks_in = count_val;
      end
      if (cmd.mul) begin
         cum_in      = '0;
         walk_idx_in = '0;
      end
      if (cmd.walk_step && !walk_hit) begin
         cum_in      = cum_next;
         walk_idx_in = walk_idx_ff + IDX_BITS'(1);
      end
      if (cmd.swap) begin
         size_in  = size_dec;
         picks_in = picks_ff - COUNT_BITS'(1);
         total_in = total_ff - TW'(pick_w_ff);
      end
   end

   // round state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= '0;
         picks_ff <= '0;
         total_ff <= '0;
      end else begin
         size_ff  <= size_in;
         picks_ff <= picks_in;
         total_ff <= total_in;
      end
   end

   // work registers
   always_ff @(posedge clock) begin
      load_ff     <= load_in;
      load_idx_ff <= load_idx_in;
      cum_ff      <= cum_in;
      walk_idx_ff <= walk_idx_in;
      if (cmd.accept) begin
         frac_ff <= frac_sat;
      end
      if (cmd.mul) begin
         target_ff <= PW'(total_ff) * PW'(frac_ff);
      end
      if (cmd.walk_step && walk_hit) begin
         pick_idx_ff   <= walk_idx_ff;
         pick_entry_ff <= rd_entry;
         pick_w_ff     <= rd_weight;
      end
   end

   // pending result word
   always_ff @(posedge clock) begin
      if (cmd.set_spent) begin
         res_entry_ff  <= '0;
         res_count_ff  <= '0;
         res_last_ff   <= 1'b0;
         res_status_ff <= STATUS_SPENT;
      end
      if (cmd.count) begin
         res_entry_ff  <= '0;
         res_count_ff  <= count_val;
         res_last_ff   <= 1'b0;
         res_status_ff <= STATUS_OK;
      end
      if (cmd.swap) begin
         res_entry_ff  <= pick_entry_ff;
         res_count_ff  <= '0;
         res_last_ff   <= (picks_ff == COUNT_BITS'(1));
         res_status_ff <= STATUS_OK;
      end
   end

   // output register, held while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_entry_ff  <= res_entry_ff;
         rsp_count_ff  <= res_count_ff;
         rsp_last_ff   <= res_last_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   // status toward the controller
   assign stat.is_start  = (req_action == ACT_START);
   assign stat.spent     = (picks_ff == '0) || (size_ff == '0);
   assign stat.load_done = (load_idx_ff == LAST_LOAD);
   assign stat.walk_hit  = walk_hit;
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_picked_entry = rsp_entry_ff;
   assign rsp_pick_count   = rsp_count_ff;
   assign rsp_last_pick    = rsp_last_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

>>> sv/wpwr_controller.sv
// controller: sequences load, count, multiply, walk and swap steps
module wpwr_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  wpwr_pkg::stat_type   stat,
   output wpwr_pkg::cmd_type    cmd
);
   import wpwr_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (stat.is_start) begin
                  cmd.load_init = 1'b1;
                  state_in      = ST_LOAD;
               end else if (stat.spent) begin
                  cmd.set_spent = 1'b1;
                  state_in      = ST_RESP;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_LOAD: begin
            cmd.load_step = 1'b1;
            if (stat.load_done) begin
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            cmd.count = 1'b1;
            state_in  = ST_RESP;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (stat.walk_hit) begin
               state_in = ST_SWAP;
            end
         end
         ST_SWAP: begin
            cmd.swap = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> sv/wpwr_checker.sv
// port level checks for the weighted pick block, bound to the top level
module wpwr_checker #(
   parameter int ENTRIES = wpwr_pkg::DEFAULT_ENTRIES
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [wpwr_pkg::IDX_BITS-1:0]        rsp_picked_entry,
   input logic [wpwr_pkg::COUNT_BITS-1:0]      rsp_pick_count,
   input logic                                 rsp_last_pick,
   input logic                                 rsp_status
);
   import wpwr_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid &&
         $stable({rsp_picked_entry, rsp_pick_count, rsp_last_pick, rsp_status}))
      else $error("result word changed while stalled");

   // reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a spent draw carries no other information
   a_spent_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_SPENT) |->
         (rsp_picked_entry == '0) && (rsp_pick_count == '0) && !rsp_last_pick)
      else $error("spent status with nonzero fields");

   // planned picks never exceed the entry count
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pick_count <= ENTRIES))
      else $error("pick count above entry count");

   // last pick only on a good draw word
   a_last_draw: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_pick |->
         (rsp_status == STATUS_OK) && (rsp_pick_count == '0))
      else $error("last pick flag on a non-draw word");

endmodule

bind weighted_pick_without_replacement_top wpwr_checker #(
   .ENTRIES (ENTRIES)
) u_wpwr_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_picked_entry (rsp_picked_entry),
   .rsp_pick_count   (rsp_pick_count),
   .rsp_last_pick    (rsp_last_pick),
   .rsp_status       (rsp_status)
);
